// ===== rtl/u8250_pkg.sv =====
// ----------------------------------------------------------------------------
// u8250_pkg: shared types and constants of the 8250 register model
// Operation and offset codes, command kinds and the decoded command record
// passed from the front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package u8250_pkg;

   // request field widths
   localparam int OP_W     = 2;
   localparam int OFS_W    = 3;
   localparam int SIZE_W   = 3;
   localparam int WDATA_W  = 32;
   localparam int BYTE_W   = 8;
   localparam int LANES    = 4;
   localparam int REQ_TDATA_W = 48;   // 3 + 3 + 32 + 8 = 46, padded to bytes
   localparam int RSP_TDATA_W = 72;   // 32 + 32 + 3 + 1 + 1 = 69, padded

   // operation codes
   localparam logic [OP_W-1:0] OP_RX    = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   // register offsets in the port window
   localparam logic [OFS_W-1:0] OFS_DATA = 3'd0;   // RBR / THR
   localparam logic [OFS_W-1:0] OFS_IER  = 3'd1;
   localparam logic [OFS_W-1:0] OFS_LCR  = 3'd3;
   localparam logic [OFS_W-1:0] OFS_LSR  = 3'd5;

   // line status bits
   localparam logic [BYTE_W-1:0] LSR_DATA_READY = 8'h01;
   localparam logic [BYTE_W-1:0] LSR_TX_EMPTY   = 8'h20;
   localparam logic [BYTE_W-1:0] LSR_IDLE       = 8'h40;

   typedef enum logic [3:0] {
      CMD_NOP    = 4'd0,
      CMD_RX     = 4'd1,
      CMD_POP    = 4'd2,
      CMD_RD_IER = 4'd3,
      CMD_RD_LCR = 4'd4,
      CMD_RD_LSR = 4'd5,
      CMD_WR_IER = 4'd6,
      CMD_WR_LCR = 4'd7,
      CMD_TX     = 4'd8,
      CMD_ERR    = 4'd9
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [2:0]         lanes;  // saturated access size, 0..4
      logic [WDATA_W-1:0] data;   // rx byte, masked tx bytes or register byte
   } cmd_type;

endpackage

// ===== rtl/u8250_front.sv =====
// ----------------------------------------------------------------------------
// u8250_front: request decode
// Takes a request apart and classifies it into one command for the back end.
// ----------------------------------------------------------------------------
module u8250_front
   import u8250_pkg::*;
(
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [OP_W-1:0]     operation,
   input  logic [OFS_W-1:0]    reg_offset,
   input  logic [SIZE_W-1:0]   xfer_size,
   input  logic [WDATA_W-1:0]  write_data,
   input  logic [BYTE_W-1:0]   rx_byte,
   output logic                push,
   input  logic                queue_ready,
   output cmd_type             cmd
);

   logic [2:0]         lanes;
   logic [WDATA_W-1:0] tx_masked;

   assign req_tready = queue_ready;
   assign push       = req_tvalid && queue_ready;

   assign lanes = (xfer_size > 3'd4) ? 3'd4 : xfer_size;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         tx_masked[i*BYTE_W +: BYTE_W] =
            (3'(i) < lanes) ? write_data[i*BYTE_W +: BYTE_W] : '0;
      end
   end

   always_comb begin
      cmd.kind  = CMD_NOP;
      cmd.lanes = lanes;
      cmd.data  = '0;
      case (operation)
         OP_RX: begin
            cmd.kind = CMD_RX;
            cmd.data = {24'd0, rx_byte};
         end
         OP_READ: begin
            case (reg_offset)
               OFS_DATA: cmd.kind = CMD_POP;
               OFS_IER:  cmd.kind = CMD_RD_IER;
               OFS_LCR:  cmd.kind = CMD_RD_LCR;
               OFS_LSR:  cmd.kind = CMD_RD_LSR;
               default:  cmd.kind = CMD_NOP;
            endcase
         end
         OP_WRITE: begin
            case (reg_offset)
               OFS_DATA: begin
                  cmd.kind = CMD_TX;
                  cmd.data = tx_masked;
               end
               OFS_IER: begin
                  cmd.kind = (xfer_size == 3'd1) ? CMD_WR_IER : CMD_ERR;
                  cmd.data = {24'd0, write_data[BYTE_W-1:0]};
               end
               OFS_LCR: begin
                  cmd.kind = (xfer_size == 3'd1) ? CMD_WR_LCR : CMD_ERR;
                  cmd.data = {24'd0, write_data[BYTE_W-1:0]};
               end
               default: cmd.kind = CMD_NOP;
            endcase
         end
         default: cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== rtl/u8250_queue.sv =====
// ----------------------------------------------------------------------------
// u8250_queue: two-entry command queue
// Decouples request decode from execution; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module u8250_queue
   import u8250_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    not_full,
   output logic    head_valid,
   input  logic    pop_ready,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign not_full   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/u8250_back.sv =====
// ----------------------------------------------------------------------------
// u8250_back: command execution and response register
// Holds IER/LCR and the receive ring. The ring is four byte-wide banks
// filled round robin, so one data read pops up to four bytes in a cycle.
// ----------------------------------------------------------------------------
module u8250_back
   import u8250_pkg::*;
#(
   parameter int RX_DEPTH = 256
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  cmd_type                cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int BANK_DEPTH = (RX_DEPTH + LANES - 1) / LANES;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RX_DEPTH + 1);

   typedef struct packed {
      logic               pop;
      logic [1:0]         rot;
      logic [2:0]         npop;
      logic [BYTE_W-1:0]  imm;
      logic [WDATA_W-1:0] tx_data;
      logic [2:0]         tx_count;
      logic               err;
      logic               drop;
   } out_meta_type;

   logic                 issue;
   logic                 full;
   logic                 is_pop;
   logic                 wr_en;
   logic [2:0]           npop;
   logic [2:0]           npop_eff;
   logic [LANES-1:0]     rd_en;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           wbank_ff, wbank_in;
   logic [1:0]           rbank_ff, rbank_in;
   logic [BANK_AW-1:0]   wr_addr_ff [LANES];
   logic [BANK_AW-1:0]   wr_addr_in [LANES];
   logic [BANK_AW-1:0]   rd_addr_ff [LANES];
   logic [BANK_AW-1:0]   rd_addr_in [LANES];
   logic [BYTE_W-1:0]    bank_q_ff [LANES];
   logic [BYTE_W-1:0]    ier_ff;
   logic [BYTE_W-1:0]    lcr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   out_meta_type         meta_ff, meta_in;
   logic [WDATA_W-1:0]   pop_data;
   logic [WDATA_W-1:0]   read_data;

   function automatic logic [BANK_AW-1:0] bank_next(input logic [BANK_AW-1:0] a);
      return (a == BANK_AW'(BANK_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_tready;
   assign issue     = cmd_valid && cmd_ready;

   assign full     = (count_ff == CNT_W'(RX_DEPTH - 1));
   assign is_pop   = (cmd.kind == CMD_POP);
   assign wr_en    = issue && (cmd.kind == CMD_RX) && !full;
   assign npop     = (count_ff < CNT_W'(cmd.lanes)) ? count_ff[2:0] : cmd.lanes;
   assign npop_eff = (issue && is_pop) ? npop : 3'd0;

   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         // bank b holds the (b - rbank)-th byte in pop order
         rd_en[b]      = ({1'b0, 2'(b) - rbank_ff} < npop_eff);
         rd_addr_in[b] = rd_en[b] ? bank_next(rd_addr_ff[b]) : rd_addr_ff[b];
         wr_addr_in[b] = (wr_en && (wbank_ff == 2'(b))) ? bank_next(wr_addr_ff[b])
                                                       : wr_addr_ff[b];
      end
      count_in = count_ff + CNT_W'(wr_en) - CNT_W'(npop_eff);
      rbank_in = rbank_ff + npop_eff[1:0];
      wbank_in = wbank_ff + {1'b0, wr_en};
   end

   always_comb begin
      meta_in          = '0;
      meta_in.pop      = is_pop;
      meta_in.rot      = rbank_ff;
      meta_in.npop     = is_pop ? npop : 3'd0;
      meta_in.drop     = (cmd.kind == CMD_RX) && full;
      meta_in.err      = (cmd.kind == CMD_ERR);
      meta_in.tx_data  = (cmd.kind == CMD_TX) ? cmd.data : '0;
      meta_in.tx_count = (cmd.kind == CMD_TX) ? cmd.lanes : 3'd0;
      case (cmd.kind)
         CMD_RD_IER: meta_in.imm = ier_ff;
         CMD_RD_LCR: meta_in.imm = lcr_ff;
         CMD_RD_LSR: meta_in.imm = (count_ff != '0) ? (LSR_IDLE | LSR_DATA_READY)
                                                   : (LSR_IDLE | LSR_TX_EMPTY);
         default:    meta_in.imm = '0;
      endcase
      rsp_valid_in = issue ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // receive ring banks
   for (genvar g = 0; g < LANES; g++) begin : g_bank
      logic [BYTE_W-1:0] bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wbank_ff == 2'(g))) begin
            bank_mem[wr_addr_ff[g]] <= cmd.data[BYTE_W-1:0];
         end
         if (rd_en[g]) begin
            bank_q_ff[g] <= bank_mem[rd_addr_ff[g]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wbank_ff     <= '0;
         rbank_ff     <= '0;
         ier_ff       <= '0;
         lcr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < LANES; b++) begin
            wr_addr_ff[b] <= '0;
            rd_addr_ff[b] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         wbank_ff     <= wbank_in;
         rbank_ff     <= rbank_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int b = 0; b < LANES; b++) begin
            wr_addr_ff[b] <= wr_addr_in[b];
            rd_addr_ff[b] <= rd_addr_in[b];
         end
         if (issue && (cmd.kind == CMD_WR_IER)) begin
            ier_ff <= cmd.data[BYTE_W-1:0];
         end
         if (issue && (cmd.kind == CMD_WR_LCR)) begin
            lcr_ff <= cmd.data[BYTE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         meta_ff <= meta_in;
      end
   end

   // popped bytes come back from the banks rotated by the head bank
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         pop_data[k*BYTE_W +: BYTE_W] =
            (3'(k) < meta_ff.npop) ? bank_q_ff[meta_ff.rot + 2'(k)] : '0;
      end
      read_data = meta_ff.pop ? pop_data : {24'd0, meta_ff.imm};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, meta_ff.drop, meta_ff.err, meta_ff.tx_count,
                        meta_ff.tx_data, read_data};

endmodule

// ===== rtl/uart_8250_register_model_core.sv =====
// ----------------------------------------------------------------------------
// uart_8250_register_model_core: 8250-style UART register file with rx ring
// Requests on req_* are receive bytes, bus reads or bus writes of the
// eight-byte register window; each yields exactly one response on rsp_*.
// A request is decoded by the front end into a two-entry command queue; the
// back end executes one command per cycle unless a held response stalls it,
// and registers the response. An accepted request is decoded into a queue
// slot, then executed from the queue into the response register.
// Throughput: one request per cycle, sustained while rsp_tready stays high;
// a data read pops up to four bytes in one cycle from four round-robin banks.
// Ring capacity is RX_DEPTH-1 bytes; a receive into a full ring is dropped
// and flagged.
// Reset clears IER, LCR, the ring pointers and both handshakes; ring
// contents are not cleared and no clearing pass is needed.
// When rsp_tready is low the response holds, the back end stops, and the
// queue absorbs up to two more requests before req_tready drops.
// ----------------------------------------------------------------------------
module uart_8250_register_model_core
   import u8250_pkg::*;
#(
   parameter int RX_DEPTH = 256
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // reg_offset, xfer_size, write_data, rx_byte
   input  logic [OP_W-1:0]        req_tuser,  // operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // read_data, tx_data, tx_count,
                                              // access_error, rx_dropped
);

   logic    push;
   logic    queue_ready;
   cmd_type push_cmd;
   logic    head_valid;
   logic    head_ready;
   cmd_type head_cmd;

   u8250_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .operation   (req_tuser),
      .reg_offset  (req_tdata[2:0]),
      .xfer_size   (req_tdata[5:3]),
      .write_data  (req_tdata[37:6]),
      .rx_byte     (req_tdata[45:38]),
      .push        (push),
      .queue_ready (queue_ready),
      .cmd         (push_cmd)
   );

   u8250_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .not_full   (queue_ready),
      .head_valid (head_valid),
      .pop_ready  (head_ready),
      .head_cmd   (head_cmd)
   );

   u8250_back #(
      .RX_DEPTH (RX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd_ready  (head_ready),
      .cmd        (head_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
